// ===== rtl/hpta_pkg.sv =====
// ----------------------------------------------------------------------------
// hpta_pkg
// Types, register indexes, constant tables and arithmetic helpers for the
// hls pixel tone adjuster.
// ----------------------------------------------------------------------------
package hpta_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_HUE_SHIFT  = 3'd0,
    REG_LIGHT_OFS  = 3'd1,
    REG_SAT_OFS    = 3'd2,
    REG_INV_GAMMA  = 3'd3,
    REG_SHADOW     = 3'd4,
    REG_HIGHLIGHT  = 3'd5,
    REG_DEPTH      = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_idx_t;

  localparam int NumStages = 20;
  localparam int StgExp0   = 3;
  localparam int ExpSteps  = 12;

  localparam logic [19:0] FULL_Q12   = 20'd1044480;
  localparam logic [13:0] GAMMA_UNIT = 14'd4096;
  localparam longint QuartDen        = 64'd6250000;

  // 2^-(2^-k) in q16, k = 1..12
  localparam logic [15:0] EXP_C [ExpSteps] = '{
    16'd46341, 16'd55109, 16'd60098, 16'd62757, 16'd64132, 16'd64830,
    16'd65183, 16'd65359, 16'd65447, 16'd65492, 16'd65514, 16'd65525
  };

  typedef logic [14:0] log_tab_t [256];
  typedef logic [21:0] qrt_tab_t [256];

  // log2 in q12 by repeated squaring of the normalized mantissa
  function automatic logic [14:0] log2_q12(int unsigned x);
    int unsigned e;
    longint unsigned m;
    int unsigned frac;
    e = 0;
    frac = 0;
    for (int i = 0; i < 7; i++) begin
      if ((x >> (e + 1)) != 0) e++;
    end
    m = longint'(x) << (15 - e);
    for (int k = 0; k < 12; k++) begin
      m = (m * m) >> 15;
      frac = frac << 1;
      if (m >= 65536) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return 15'(e * 4096 + frac);
  endfunction

  function automatic log_tab_t make_log_tab();
    log_tab_t r;
    for (int i = 0; i < 256; i++) r[i] = log2_q12(i);
    return r;
  endfunction

  // floor(b^4 * 4096 / 50^4)
  function automatic qrt_tab_t make_qrt_tab();
    qrt_tab_t r;
    longint b2;
    for (int i = 0; i < 256; i++) begin
      b2 = longint'(i) * longint'(i);
      r[i] = 22'((b2 * b2 * 4096) / QuartDen);
    end
    return r;
  endfunction

  localparam log_tab_t LOG_TAB = make_log_tab();
  localparam qrt_tab_t QRT_TAB = make_qrt_tab();
  localparam logic [14:0] LOG_255 = LOG_TAB[255];

  // shadow or highlight contribution, q12
  function automatic logic signed [24:0] qterm(logic signed [7:0] a, logic [21:0] q);
    logic signed [24:0] aa;
    logic signed [24:0] qq;
    logic signed [24:0] t;
    aa = {{5{a[7]}}, a, 12'b0};
    qq = {3'b0, q};
    t = '0;
    if (a > 8'sd0) begin
      t = aa - qq;
      if (t < 25'sd0) t = '0;
    end else if (a < 8'sd0) begin
      t = qq + aa;
      if (t > 25'sd0) t = '0;
    end
    return t;
  endfunction

  // floor(v / 510) for v < 65536
  function automatic logic [7:0] div510(logic [15:0] v);
    logic [24:0] pr;
    logic [7:0] q;
    logic [16:0] rem;
    pr = 25'(v) * 25'd257;
    q = pr[24:17];
    rem = 17'(v) - 17'(q) * 17'd510;
    if (rem >= 17'd510) q = q + 8'd1;
    return q;
  endfunction

  // floor(v / 255) for v < 32768
  function automatic logic [7:0] div255(logic [15:0] v);
    logic [24:0] pr;
    logic [8:0] q;
    logic [16:0] rem;
    pr = 25'(v) * 25'd257;
    q = pr[24:16];
    rem = 17'(v) - 17'(q) * 17'd255;
    if (rem >= 17'd255) q = q + 9'd1;
    return q[7:0];
  endfunction

  // v mod 30 for v <= 256
  function automatic logic [4:0] mod30(logic [8:0] v);
    logic [13:0] pr;
    logic [4:0] q;
    logic [8:0] rem;
    pr = 14'(v) * 14'd17;
    q = pr[13:9];
    rem = v - 9'(q) * 9'd30;
    if (rem >= 9'd30) rem = rem - 9'd30;
    return rem[4:0];
  endfunction

  // payload carried down the pipeline
  typedef struct packed {
    logic [7:0]         h;
    logic [7:0]         s;
    logic [7:0]         l;
    logic [14:0]        d;
    logic [16:0]        t;
    logic [16:0]        p;
    logic signed [24:0] ts;
    logic signed [24:0] th;
    logic [20:0]        g;
    logic [8:0]         hn;
    logic [4:0]         hr;
    logic [12:0]        hx;
    logic [8:0]         ln;
    logic [6:0]         lr;
    logic [15:0]        lx;
    logic [7:0]         hd;
    logic [7:0]         ld;
  } pay_t;

endpackage

// ===== rtl/hls_pixel_tone_adjust.sv =====
// ----------------------------------------------------------------------------
// hls_pixel_tone_adjust
// Hue rotation, lightness tone curve with shadow/highlight terms, saturation
// offset and optional depth quantization on a stream of hls pixels.
// ----------------------------------------------------------------------------
// One pixel is taken per clock unless an output stall has backed up to the
// first stage. Most of the stages serve the twelve-step multiply chain that
// builds the fractional power of two for the gamma curve, one multiply per
// stage. Every stage holds its own valid bit, so empty stages fill while the
// output waits. Configuration writes are meant for idle periods only.
module hls_pixel_tone_adjust
  import hpta_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [13:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // hue_in[7:0], light_in[15:8], sat_in[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // hue_out[7:0], light_out[15:8], sat_out[23:16]
);

  logic signed [8:0] hue_shift;
  logic signed [8:0] lightness_offset;
  logic signed [8:0] saturation_offset;
  logic [13:0]       inverse_gamma;
  logic signed [7:0] shadow_amount;
  logic signed [7:0] highlight_amount;
  logic [7:0]        depth_level;

  pay_t stg      [NumStages];
  pay_t stg_next [NumStages];
  logic vld      [NumStages];
  logic rdy      [NumStages+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_shift         <= '0;
      lightness_offset  <= '0;
      saturation_offset <= '0;
      inverse_gamma     <= GAMMA_UNIT;
      shadow_amount     <= '0;
      highlight_amount  <= '0;
      depth_level       <= 8'd255;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_HUE_SHIFT: hue_shift         <= cfg_data[8:0];
        REG_LIGHT_OFS: lightness_offset  <= cfg_data[8:0];
        REG_SAT_OFS:   saturation_offset <= cfg_data[8:0];
        REG_INV_GAMMA: inverse_gamma     <= cfg_data;
        REG_SHADOW:    shadow_amount     <= cfg_data[7:0];
        REG_HIGHLIGHT: highlight_amount  <= cfg_data[7:0];
        REG_DEPTH:     depth_level       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // per-stage ready: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[NumStages] = m_axis_tready;
    for (int i = NumStages - 1; i >= 0; i--) rdy[i] = !vld[i] || rdy[i+1];
  end

  assign s_axis_tready = rdy[0];

  // stage datapath
  always_comb begin
    logic signed [9:0]  hs;
    logic signed [9:0]  lt;
    logic signed [9:0]  st;
    logic [7:0]         hin;
    logic [28:0]        dg;
    logic [32:0]        pr;
    logic [24:0]        y25;
    logic [20:0]        y;
    logic signed [26:0] acc;
    logic [7:0]         num;
    logic [9:0]         lq;
    stg_next[0] = '0;
    for (int i = 1; i < NumStages; i++) stg_next[i] = stg[i-1];
    lq = '0;

    // stage 0: hue rotation and saturating offsets
    hin = s_axis_tdata[7:0];
    hs  = $signed({2'b0, hin}) + 10'(hue_shift);
    if (hs < 10'sd0) hs = hs + 10'sd180;
    else if (hs > 10'sd179) hs = hs - 10'sd180;
    stg_next[0].h = (hin < 8'd180) ? hs[7:0] : hin;
    lt = $signed({2'b0, s_axis_tdata[15:8]}) + 10'(lightness_offset);
    st = $signed({2'b0, s_axis_tdata[23:16]}) + 10'(saturation_offset);
    stg_next[0].l = (lt < 10'sd0) ? 8'd0 : ((lt > 10'sd255) ? 8'd255 : lt[7:0]);
    stg_next[0].s = (st < 10'sd0) ? 8'd0 : ((st > 10'sd255) ? 8'd255 : st[7:0]);

    // stage 1: log distance and quartic terms
    stg_next[1].d  = LOG_255 - LOG_TAB[stg[0].l];
    stg_next[1].ts = (stg[0].l < 8'd149) ? qterm(shadow_amount, QRT_TAB[stg[0].l]) : '0;
    stg_next[1].th = (stg[0].l > 8'd106) ?
                     qterm(highlight_amount, QRT_TAB[8'd255 - stg[0].l]) : '0;

    // stage 2: exponent scaled by inverse gamma
    dg = 29'(stg[1].d) * 29'(inverse_gamma);
    stg_next[2].t = 17'((30'(dg) + 30'd2048) >> 12);
    stg_next[2].p = 17'd65536;

    // exponent stages: one rounded q16 multiply each, applied when its exponent bit is set
    for (int k = 0; k < ExpSteps; k++) begin
      pr = 33'(stg[StgExp0+k-1].p) * 33'(EXP_C[k]);
      if (stg[StgExp0+k-1].t[11-k])
        stg_next[StgExp0+k].p = 17'((34'(pr) + 34'd32768) >> 16);
    end

    // stage 15: curve value
    y25 = 25'(stg[14].p) * 25'd255;
    y   = 21'(y25 >> 4);
    if (inverse_gamma == '0) stg_next[15].g = 21'(FULL_Q12);
    else if (stg[14].l == '0) stg_next[15].g = '0;
    else if (inverse_gamma == GAMMA_UNIT) stg_next[15].g = {1'b0, stg[14].l, 12'b0};
    else stg_next[15].g = y >> stg[14].t[16:12];

    // stage 16: sum and clamp
    acc = $signed({6'b0, stg[15].g}) + 27'(stg[15].ts) + 27'(stg[15].th);
    if (acc < 27'sd0) stg_next[16].l = 8'd0;
    else if (acc > $signed({7'b0, FULL_Q12})) stg_next[16].l = 8'd255;
    else stg_next[16].l = acc[19:12];

    // stage 17: sector remainders and scaled distances
    num = 8'd255 - depth_level;
    stg_next[17].hn = {1'b0, stg[16].h} + 9'd1;
    stg_next[17].hr = mod30({1'b0, stg[16].h} + 9'd1);
    stg_next[17].hx = (stg_next[17].hr <= 5'd15) ? 13'(stg_next[17].hr) * 13'(num)
                                                 : 13'(5'd30 - stg_next[17].hr) * 13'(num);
    stg_next[17].ln = {1'b0, stg[16].l} + 9'd1;
    stg_next[17].lr = stg_next[17].ln[6:0];
    stg_next[17].lx = (stg_next[17].lr <= 7'd64) ? 16'(stg_next[17].lr) * 16'(num)
                                                 : 16'(8'd128 - 8'(stg_next[17].lr)) * 16'(num);

    // stage 18: constant divisions
    stg_next[18].hd = div510(16'({stg[17].hx, 1'b0}) + 16'd255);
    stg_next[18].ld = (stg[17].lr <= 7'd64) ? div510({stg[17].lx[14:0], 1'b0} + 16'd255)
                                            : div255(stg[17].lx);

    // stage 19: apply quantization
    if (depth_level != 8'd255) begin
      if (stg[18].h < 8'd180)
        stg_next[19].h = (stg[18].hr <= 5'd15) ? 8'(stg[18].hn - 9'(stg[18].hd))
                                               : 8'(stg[18].hn + 9'(stg[18].hd));
      lq = (stg[18].lr <= 7'd64) ? 10'(stg[18].ln) - 10'(stg[18].ld)
                                 : 10'(stg[18].ln) + 10'(stg[18].ld);
      stg_next[19].l = (lq > 10'd255) ? 8'd255 : lq[7:0];
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < NumStages; i++) begin
      if (rdy[i]) stg[i] <= stg_next[i];
    end
    if (rst) begin
      for (int i = 0; i < NumStages; i++) vld[i] <= 1'b0;
    end else begin
      if (rdy[0]) vld[0] <= s_axis_tvalid;
      for (int i = 1; i < NumStages; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign m_axis_tvalid = vld[NumStages-1];
  assign m_axis_tdata  = {stg[NumStages-1].s, stg[NumStages-1].l, stg[NumStages-1].h};

endmodule

// ===== rtl/hpta_checker.sv =====
// ----------------------------------------------------------------------------
// hpta_checker
// Port-level checks for the hls pixel tone adjuster, bound to the top level.
// ----------------------------------------------------------------------------
module hpta_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // an empty output stage never holds back a request
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a moving output never holds back a request
  a_flow_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output moves");

endmodule

bind hls_pixel_tone_adjust hpta_checker u_hpta_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/hls_pixel_tone_adjust_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hls_pixel_tone_adjust_tb
// Streams hls pixels through the tone adjuster under a series of register
// settings: defaults, both range extremes, out-of-range bit patterns and
// random settings. A bit-exact fixed point predictor computes every adjusted
// pixel at input acceptance; each output request is checked in order.
// ----------------------------------------------------------------------------
module hls_pixel_tone_adjust_tb;
  import hpta_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [13:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // hue_in[7:0], light_in[15:8], sat_in[23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // hue_out[7:0], light_out[15:8], sat_out[23:16]

  hls_pixel_tone_adjust i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // shadow copy of the register file
  logic signed [8:0] shift_r;
  logic signed [8:0] lofs_r;
  logic signed [8:0] sofs_r;
  logic [13:0]       igam_r;
  logic signed [7:0] shadow_r;
  logic signed [7:0] hilite_r;
  logic [7:0]        depth_r;

  logic [23:0] pixel_q[$];
  logic [23:0] adjusted_q[$];
  int          errors = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          calm = 0;

  // q16 factors 2^-(2^-k), k = 1..12
  localparam longint unsigned FracPow [12] = '{
    46341, 55109, 60098, 62757, 64132, 64830,
    65183, 65359, 65447, 65492, 65514, 65525
  };

  function automatic longint unsigned log_fix(longint unsigned x);
    int e;
    longint unsigned m;
    longint unsigned frac;
    e = 0;
    frac = 0;
    while (e < 7 && (x >> (e + 1)) != 0) e++;
    m = x << (15 - e);
    for (int k = 0; k < 12; k++) begin
      m = (m * m) >> 15;
      frac = frac << 1;
      if (m >= 65536) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(e) * 4096 + frac;
  endfunction

  function automatic longint tone_curve(longint unsigned x, longint unsigned g);
    longint unsigned d, t, n, p, y;
    if (g == 0) return 255 * 4096;
    if (x == 0) return 0;
    if (g == 4096) return x << 12;
    d = log_fix(255) - log_fix(x);
    t = (d * g + 2048) >> 12;
    n = t >> 12;
    p = 65536;
    for (int k = 0; k < 12; k++)
      if ((t >> (11 - k)) & 1) p = (p * FracPow[k] + 32768) >> 16;
    y = (255 * p) >> 4;
    if (n >= 32) return 0;
    return longint'(y >> n);
  endfunction

  function automatic longint quart_lift(longint amt, longint unsigned b);
    longint q, term;
    q = longint'((b * b * b * b * 4096) / 6250000);
    if (amt > 0) begin
      term = amt * 4096 - q;
      return term > 0 ? term : 0;
    end
    if (amt < 0) begin
      term = q + amt * 4096;
      return term < 0 ? term : 0;
    end
    return 0;
  endfunction

  function automatic longint clip_byte(longint v);
    return v < 0 ? 0 : (v > 255 ? 255 : v);
  endfunction

  function automatic longint div_round(longint num, longint den);
    return (2 * num + den) / (2 * den);
  endfunction

  // adjusted pixel for one input request under the current registers
  function automatic logic [23:0] adjust_pixel(logic [23:0] px);
    longint h, l, s, acc, num, r;
    h = px[7:0];
    l = px[15:8];
    s = px[23:16];
    if (h < 180) begin
      h = h + shift_r;
      if (h < 0) h = h + 180;
      else if (h > 179) h = h - 180;
      h = h & 255;
    end
    l = clip_byte(l + lofs_r);
    s = clip_byte(s + sofs_r);
    acc = tone_curve(l, igam_r);
    if (l < 149) acc = acc + quart_lift(shadow_r, l);
    if (l > 106) acc = acc + quart_lift(hilite_r, 255 - l);
    if (acc < 0) acc = 0;
    if (acc > 255 * 4096) acc = 255 * 4096;
    l = acc >>> 12;
    if (depth_r < 255) begin
      num = 255 - depth_r;
      if (h < 180) begin
        r = (h + 1) % 30;
        if (r <= 15) h = h + 1 - div_round(r * num, 255);
        else h = h + 1 + div_round((30 - r) * num, 255);
      end
      r = (l + 1) % 128;
      if (r <= 64) l = l + 1 - div_round(r * num, 255);
      else l = l + 1 + ((128 - r) * num) / 255;
      if (l > 255) l = 255;
    end
    return {s[7:0], l[7:0], h[7:0]};
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // input side driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        adjusted_q.push_back(adjust_pixel(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          s_axis_tdata  <= pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          in_gap = calm ? 0 : $urandom_range(0, 5);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (adjusted_q.size() == 0) begin
          $error("unexpected output request %h", m_axis_tdata);
          errors++;
        end else begin
          logic [23:0] want;
          want = adjusted_q.pop_front();
          if (want[7:0] !== m_axis_tdata[7:0]) begin
            $error("hue_out expected %0d actual %0d", want[7:0], m_axis_tdata[7:0]);
            errors++;
          end
          if (want[15:8] !== m_axis_tdata[15:8]) begin
            $error("light_out expected %0d actual %0d", want[15:8], m_axis_tdata[15:8]);
            errors++;
          end
          if (want[23:16] !== m_axis_tdata[23:16]) begin
            $error("sat_out expected %0d actual %0d", want[23:16], m_axis_tdata[23:16]);
            errors++;
          end
        end
        out_gap = calm ? 0 : $urandom_range(0, 5);
      end
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // register write, mirrored into the shadow copy
  task automatic write_reg(reg_idx_t idx, logic [13:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_HUE_SHIFT: shift_r  = val[8:0];
      REG_LIGHT_OFS: lofs_r   = val[8:0];
      REG_SAT_OFS:   sofs_r   = val[8:0];
      REG_INV_GAMMA: igam_r   = val;
      REG_SHADOW:    shadow_r = val[7:0];
      REG_HIGHLIGHT: hilite_r = val[7:0];
      REG_DEPTH:     depth_r  = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(int hs, int lo, int so, int ig, int sa, int ha, int dl);
    write_reg(REG_HUE_SHIFT, 14'(hs));
    write_reg(REG_LIGHT_OFS, 14'(lo));
    write_reg(REG_SAT_OFS, 14'(so));
    write_reg(REG_INV_GAMMA, 14'(ig));
    write_reg(REG_SHADOW, 14'(sa));
    write_reg(REG_HIGHLIGHT, 14'(ha));
    write_reg(REG_DEPTH, 14'(dl));
  endtask

  // wait for the pipeline to drain completely
  task automatic drain();
    wait (pixel_q.size() == 0 && !s_axis_tvalid && adjusted_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_random(int count);
    logic [7:0] h;
    for (int i = 0; i < count; i++) begin
      h = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 179));
      pixel_q.push_back({8'($urandom), 8'($urandom), h});
    end
  endtask

  task automatic push_corners();
    int lights [10] = '{0, 1, 106, 107, 127, 148, 149, 200, 254, 255};
    for (int i = 0; i < 10; i++)
      pixel_q.push_back({8'(lights[i] ^ 8'hff), 8'(lights[i]), 8'(i * 20)});
    pixel_q.push_back({8'd0, 8'd255, 8'd179});
    pixel_q.push_back({8'd255, 8'd0, 8'd180});
    pixel_q.push_back({8'd128, 8'd128, 8'd255});
    pixel_q.push_back({8'd1, 8'd254, 8'd29});
  endtask

  // stimulus sequence
  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_data      = '0;
    shift_r  = 9'sd0;
    lofs_r   = 9'sd0;
    sofs_r   = 9'sd0;
    igam_r   = GAMMA_UNIT;
    shadow_r = 8'sd0;
    hilite_r = 8'sd0;
    depth_r  = 8'd255;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset values, then range extremes
    push_corners();
    drain();
    write_all(180, 255, 255, 8192, 80, 80, 0);
    push_corners();
    drain();
    write_all(-180, -255, -255, 1365, -80, -80, 254);
    push_corners();
    drain();
    // out-of-range bit patterns and the ignored index
    write_all(255, 0, 0, 0, 127, -128, 1);
    write_reg(REG_UNUSED, 14'h3fff);
    push_corners();
    drain();
    write_all(-256, 10, -10, 16383, -128, 127, 128);
    push_corners();
    drain();

    // random settings, some with no idling at all
    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph % 4 == 3);
      write_all($urandom_range(0, 360) - 180, $urandom_range(0, 510) - 255,
                $urandom_range(0, 510) - 255,
                ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(1365, 8192),
                $urandom_range(0, 160) - 80, $urandom_range(0, 160) - 80,
                ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 255));
      push_random(155);
      drain();
    end

    if (errors == 0) begin
      $display("hls_pixel_tone_adjust: match");
    end else begin
      $display("hls_pixel_tone_adjust: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("hls_pixel_tone_adjust: mismatch");
    $finish;
  end

endmodule
